// ===== sv/b32d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32d_pkg: shared definitions for the strict Base32 decoder
// Result kinds, character codes and the types passed between the top level
// and the group decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_END_OK = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam int GROUP_LEN = 8;
	localparam int MAX_BYTES = 5;

	// Symbols of one full group, index 0 first received.
	typedef logic [GROUP_LEN-1:0][7:0] grp_syms_t;

	// Outcome of decoding one full group.
	typedef struct packed {
		logic                      ok;
		logic                      padded;
		logic [2:0]                nbytes;
		logic [MAX_BYTES-1:0][7:0] bytes;
	} grp_res_t;

endpackage

// ===== sv/b32d_group.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32d_group: decoder for one complete group of eight Base32 symbols
// Finds the trailing pad run, checks the alphabet and the unused low bits,
// and returns the decoded bytes most significant first.
// ----------------------------------------------------------------------------
module b32d_group (
	input  b32d_pkg::grp_syms_t syms,
	output b32d_pkg::grp_res_t  res
);
	import b32d_pkg::*;

	logic [3:0]  np;
	logic        run;
	logic [2:0]  nbytes;
	logic        sym_ok;
	logic        bits_ok;
	logic [39:0] v;
	logic [5:0]  sv;

	// Bit 5 flags a symbol of the alphabet, bits 4:0 carry its value.
	function automatic logic [5:0] sym_value(input logic [7:0] c);
		logic [5:0] r;
		r = 6'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			r = {1'b1, 5'(c - 8'h41)};
		end else if (c inside {[8'h32:8'h37]}) begin
			r = {1'b1, 5'(c - 8'h32 + 8'd26)};
		end
		return r;
	endfunction

	// Number of bytes for a pad run; zero marks a run that is not allowed.
	function automatic logic [2:0] bytes_for_pad(input logic [3:0] n);
		logic [2:0] r;
		case (n)
			4'd0:    r = 3'd5;
			4'd1:    r = 3'd4;
			4'd3:    r = 3'd3;
			4'd4:    r = 3'd2;
			4'd6:    r = 3'd1;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	always_comb begin
		np  = 4'd0;
		run = 1'b1;
		for (int k = 0; k < GROUP_LEN; k++) begin
			if (run && syms[GROUP_LEN-1-k] == PAD_CHAR) begin
				np = np + 4'd1;
			end else begin
				run = 1'b0;
			end
		end
		nbytes = bytes_for_pad(np);

		sym_ok = 1'b1;
		v      = '0;
		sv     = '0;
		for (int k = 0; k < GROUP_LEN; k++) begin
			if (4'(k) < 4'(GROUP_LEN) - np) begin
				sv = sym_value(syms[k]);
				if (!sv[5]) begin
					sym_ok = 1'b0;
				end
				v[39-5*k -: 5] = sv[4:0];
			end
		end

		case (nbytes)
			3'd5:    bits_ok = 1'b1;
			3'd4:    bits_ok = (v[7:0] == '0);
			3'd3:    bits_ok = (v[15:0] == '0);
			3'd2:    bits_ok = (v[23:0] == '0);
			3'd1:    bits_ok = (v[31:0] == '0);
			default: bits_ok = 1'b0;
		endcase

		res.ok     = (nbytes != 3'd0) && sym_ok && bits_ok;
		res.padded = (np != 4'd0);
		res.nbytes = nbytes;
		for (int k = 0; k < MAX_BYTES; k++) begin
			res.bytes[k] = v[39-8*k -: 8];
		end
	end

endmodule

// ===== sv/base32_strict_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_strict_decoder_top: strict Base32 text decoder
// Takes one character per transaction, gathers groups of eight symbols and
// emits the decoded bytes, an end status or a single error result.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_ready, symbol, is_end   | sink
//  out     | out_valid, out_ready, out_byte, kind,| source
//          | last_of_run                          |
//
// One character is accepted per cycle; it is decoded in the cycle after it is
// registered, and a full group is checked in that same single pass. A group
// gives up to five results, shifted out of the result register one per cycle
// while out_ready is high. Characters that give no result keep flowing while
// it drains; one that gives a result waits in the input register until it is
// free. Reset clears all control state; the group store needs no clearing.
module base32_strict_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] symbol,
	input  logic       is_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic       last_of_run
);
	import b32d_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [7:0] symbol_s1;
	logic       is_end_s1;

	// Decoder state.
	logic [7:0] grp_q [GROUP_LEN-1];
	logic [2:0] count_q;
	logic       padded_q;
	logic       err_q;

	// Result register, drained as a shift line.
	logic                      valid_s2;
	logic [MAX_BYTES-1:0][7:0] bytes_s2;
	logic [1:0]                kind_s2;
	logic [2:0]                rem_s2;

	logic      is_ws;
	logic      produces;
	logic      res_free;
	logic      fire_s1;
	grp_syms_t syms;
	grp_res_t  grp;

	always_comb begin
		for (int k = 0; k < GROUP_LEN - 1; k++) begin
			syms[k] = grp_q[k];
		end
		syms[GROUP_LEN-1] = symbol_s1;
	end

	b32d_group u_group (
		.syms (syms),
		.res  (grp)
	);

	assign is_ws = (symbol_s1 == CHAR_TAB) || (symbol_s1 == CHAR_LF) ||
	               (symbol_s1 == CHAR_CR) || (symbol_s1 == CHAR_SPACE);

	assign produces = is_end_s1 ||
	                  (!is_ws && !err_q && (padded_q || count_q == 3'(GROUP_LEN - 1)));

	// The result register is free if empty or if its last result leaves now.
	assign res_free = !valid_s2 || (out_ready && rem_s2 == 3'd1);
	assign fire_s1  = valid_s1 && (!produces || res_free);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			symbol_s1 <= symbol;
			is_end_s1 <= is_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			padded_q <= 1'b0;
			err_q    <= 1'b0;
		end else if (fire_s1) begin
			if (is_end_s1) begin
				count_q  <= '0;
				padded_q <= 1'b0;
				err_q    <= 1'b0;
			end else if (!is_ws && !err_q) begin
				if (padded_q) begin
					err_q <= 1'b1;
				end else if (count_q != 3'(GROUP_LEN - 1)) begin
					count_q <= count_q + 3'd1;
				end else begin
					count_q <= '0;
					if (!grp.ok) begin
						err_q <= 1'b1;
					end else if (grp.padded) begin
						padded_q <= 1'b1;
					end
				end
			end
		end
	end

	// Only the first seven symbols are stored; the eighth is decoded directly.
	always_ff @(posedge clk) begin
		if (fire_s1 && !is_end_s1 && !is_ws && !err_q && !padded_q &&
		    count_q != 3'(GROUP_LEN - 1)) begin
			grp_q[count_q] <= symbol_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			rem_s2   <= '0;
		end else if (fire_s1 && produces) begin
			valid_s2 <= 1'b1;
			if (is_end_s1 || padded_q || !grp.ok) begin
				rem_s2 <= 3'd1;
			end else begin
				rem_s2 <= grp.nbytes;
			end
		end else if (valid_s2 && out_ready) begin
			if (rem_s2 == 3'd1) begin
				valid_s2 <= 1'b0;
			end
			rem_s2 <= rem_s2 - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && produces) begin
			if (is_end_s1) begin
				bytes_s2 <= '0;
				kind_s2  <= (err_q || count_q != 3'd0) ? KIND_ERROR : KIND_END_OK;
			end else if (padded_q || !grp.ok) begin
				bytes_s2 <= '0;
				kind_s2  <= KIND_ERROR;
			end else begin
				bytes_s2 <= grp.bytes;
				kind_s2  <= KIND_DATA;
			end
		end else if (valid_s2 && out_ready) begin
			for (int k = 0; k < MAX_BYTES - 1; k++) begin
				bytes_s2[k] <= bytes_s2[k+1];
			end
			bytes_s2[MAX_BYTES-1] <= '0;
		end
	end

	assign out_valid   = valid_s2;
	assign out_byte    = bytes_s2[0];
	assign kind        = kind_s2;
	assign last_of_run = (rem_s2 == 3'd1);

endmodule
